@@ hw/rtl/gda_pkg.sv @@
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar tables for the Gregorian date
// attribute pipeline.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  // internal year is offset by a whole 400-year cycle so nothing goes negative
  localparam int          YY_W        = 15;
  localparam logic [14:0] YEAR_OFFSET = 15'd400;

  // y / 100 as (y * 5243) >> 19, exact for y below 43690
  localparam int          DIV100_W     = 13;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam int          DIV100_PW    = YY_W + DIV100_W;

  // x / 7 as (x * 293) >> 11, exact for x below 683
  localparam int         DIV7_MUL_W = 9;
  localparam logic [8:0] DIV7_MUL   = 9'd293;
  localparam int         DIV7_SHIFT = 11;
  localparam int         DIV7_PW    = 9 + DIV7_MUL_W;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [2:0] WD_SUN = 3'd0;
  localparam logic [2:0] WD_WED = 3'd3;
  localparam logic [2:0] WD_THU = 3'd4;
  localparam logic [2:0] WD_SAT = 3'd6;
  localparam logic [2:0] ISO_SUN = 3'd7;

  localparam logic [5:0] ISO_WEEKS_SHORT = 6'd52;
  localparam logic [5:0] ISO_WEEKS_LONG  = 6'd53;
  localparam logic [5:0] ISO_WEEK_FIRST  = 6'd1;

  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] weekday;
    logic [8:0] ordinal_day;
    logic [5:0] iso_week;
    logic       leap_year;
    logic [4:0] month_length;
  } attr_t;

  // year stage -> calendar stage
  typedef struct packed {
    logic       leap;
    logic       leap_prev;
    logic [6:0] k;      // Zeller year of century
    logic [7:0] j;      // Zeller century
    logic [3:0] month;
    logic [4:0] day;
  } yr_t;

  // calendar stage -> week stage
  typedef struct packed {
    logic       ok;
    logic [2:0] wd;
    logic [2:0] doy_m7;
    logic [8:0] doy;
    logic [4:0] mlen;
    logic       leap;
    logic       leap_prev;
  } cal_t;

  function automatic logic [4:0] base_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                  r = 5'd30;
      4'd2:                                     r = 5'd28;
      default:                                  r = 5'd0;
    endcase
    return r;
  endfunction

  // days in the months before m, common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // floor(13 * (m' + 1) / 5), with January and February as months 13 and 14
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd1:    r = 6'd36;
      4'd2:    r = 6'd39;
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // mod 7 by folding octal digits, since 8 == 1 (mod 7)
  function automatic logic [2:0] mod7(input logic [10:0] s);
    logic [4:0] a;
    logic [3:0] b;
    a = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[10:9]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    if (b >= 4'd7) b = b - 4'd7;
    return b[2:0];
  endfunction

endpackage

@@ hw/rtl/gda_year.sv @@
// ----------------------------------------------------------------------------
// gda_year
// Two stages: offset year and divide by 100 by reciprocal multiply, then
// remainder, leap flags for this and the previous year, Zeller k and j.
// ----------------------------------------------------------------------------
module gda_year (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          up_valid,
  input  gda_pkg::date_t up,
  output logic          dn_valid,
  output gda_pkg::yr_t  dn
);
  import gda_pkg::*;

  logic                 s1_valid;
  logic [YY_W-1:0]      s1_y;
  logic [DIV100_PW-1:0] s1_prod;
  logic [3:0]           s1_month;
  logic [4:0]           s1_day;

  logic [YY_W-1:0] y_next;
  logic [7:0]      q;
  logic [YY_W-1:0] r_full;
  logic [6:0]      r;
  logic [6:0]      rp;
  logic [7:0]      qp;
  yr_t             dn_next;

  assign y_next = YY_W'(up.year) + YEAR_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= up_valid;
    end
    if (en) begin
      s1_y     <= y_next;
      s1_prod  <= DIV100_PW'(y_next) * DIV100_PW'(DIV100_MUL);
      s1_month <= up.month;
      s1_day   <= up.day;
    end
  end

  always_comb begin
    q      = s1_prod[DIV100_SHIFT +: 8];
    r_full = s1_y - YY_W'(q) * YY_W'(100);
    r      = r_full[6:0];
    // previous year's century split
    if (r == 7'd0) begin
      rp = 7'd99;
      qp = q - 8'd1;
    end else begin
      rp = r - 7'd1;
      qp = q;
    end
    dn_next.leap      = ((r[1:0] == 2'd0) && (r != 7'd0)) ||
                        ((r == 7'd0) && (q[1:0] == 2'd0));
    dn_next.leap_prev = ((rp[1:0] == 2'd0) && (rp != 7'd0)) ||
                        ((rp == 7'd0) && (qp[1:0] == 2'd0));
    // Zeller counts January and February in the year before
    if (s1_month < MONTH_MAR) begin
      dn_next.k = rp;
      dn_next.j = qp;
    end else begin
      dn_next.k = r;
      dn_next.j = q;
    end
    dn_next.month = s1_month;
    dn_next.day   = s1_day;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= s1_valid;
    end
    if (en) begin
      dn <= dn_next;
    end
  end

endmodule

@@ hw/rtl/gda_cal.sv @@
// ----------------------------------------------------------------------------
// gda_cal
// Two stages: date check, month length, day of year and the Zeller sum;
// then the sum and day of year reduced mod 7, weekday with Sunday as 0.
// ----------------------------------------------------------------------------
module gda_cal (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         up_valid,
  input  gda_pkg::yr_t up,
  output logic         dn_valid,
  output gda_pkg::cal_t dn
);
  import gda_pkg::*;

  logic        s3_valid;
  logic        s3_ok;
  logic [10:0] s3_zsum;
  logic [8:0]  s3_doy;
  logic [4:0]  s3_mlen;
  logic        s3_leap;
  logic        s3_leap_prev;

  logic [4:0]  mlen_next;
  logic        ok_next;
  logic [8:0]  doy_next;
  logic [10:0] zsum_next;
  logic [2:0]  h;
  cal_t        dn_next;

  always_comb begin
    if ((up.month == MONTH_FEB) && up.leap) begin
      mlen_next = FEB_LEAP_LEN;
    end else begin
      mlen_next = base_len(up.month);
    end
    ok_next  = (mlen_next != 5'd0) && (up.day != 5'd0) && (up.day <= mlen_next);
    doy_next = cum_days(up.month) + 9'(up.day) +
               9'(up.leap && (up.month > MONTH_FEB));
    zsum_next = 11'(up.day) + 11'(month_term(up.month)) + 11'(up.k) +
                11'(up.k[6:2]) + 11'(up.j[7:2]) + {1'b0, up.j, 2'b00} + 11'(up.j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= up_valid;
    end
    if (en) begin
      s3_ok        <= ok_next;
      s3_zsum      <= zsum_next;
      s3_doy       <= doy_next;
      s3_mlen      <= mlen_next;
      s3_leap      <= up.leap;
      s3_leap_prev <= up.leap_prev;
    end
  end

  always_comb begin
    h = mod7(s3_zsum);
    // Zeller h has Saturday as 0
    dn_next.wd        = (h == 3'd0) ? WD_SAT : h - 3'd1;
    dn_next.doy_m7    = mod7(11'(s3_doy));
    dn_next.ok        = s3_ok;
    dn_next.doy       = s3_doy;
    dn_next.mlen      = s3_mlen;
    dn_next.leap      = s3_leap;
    dn_next.leap_prev = s3_leap_prev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= s3_valid;
    end
    if (en) begin
      dn <= dn_next;
    end
  end

endmodule

@@ hw/rtl/gda_week.sv @@
// ----------------------------------------------------------------------------
// gda_week
// Two stages: raw ISO week by reciprocal divide, weekday of 1 January and
// 53-week flags for this and the previous year; then the year-boundary fixup
// and the output register.
// ----------------------------------------------------------------------------
module gda_week (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          up_valid,
  input  gda_pkg::cal_t up,
  output logic          dn_valid,
  output gda_pkg::attr_t dn
);
  import gda_pkg::*;

  logic       s5_valid;
  logic       s5_ok;
  logic [2:0] s5_wd;
  logic [5:0] s5_wk;
  logic       s5_long_cur;
  logic       s5_long_prev;
  logic [8:0] s5_doy;
  logic [4:0] s5_mlen;
  logic       s5_leap;

  logic [2:0]         isowd;
  logic [8:0]         x;
  logic [DIV7_PW-1:0] prod;
  logic [3:0]         t;
  logic [2:0]         jan1;
  logic [3:0]         tp;
  logic [2:0]         jan1_prev;
  logic               long_cur;
  logic               long_prev;

  logic [5:0] weeks_cur;
  logic [5:0] wk_fix;
  attr_t      dn_next;

  always_comb begin
    isowd = (up.wd == WD_SUN) ? ISO_SUN : up.wd;
    x     = up.doy + 9'd10 - 9'(isowd);
    prod  = DIV7_PW'(x) * DIV7_PW'(DIV7_MUL);
    // 1 January falls (doy - 1) days before this date
    t = 4'(up.wd) + 4'd8 - 4'(up.doy_m7);
    if (t >= 4'd14) begin
      t = t - 4'd14;
    end else if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    jan1 = t[2:0];
    tp = 4'(jan1) + 4'd6 - 4'(up.leap_prev);
    if (tp >= 4'd7) tp = tp - 4'd7;
    jan1_prev = tp[2:0];
    long_cur  = (jan1 == WD_THU) || ((jan1 == WD_WED) && up.leap);
    long_prev = (jan1_prev == WD_THU) || ((jan1_prev == WD_WED) && up.leap_prev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= up_valid;
    end
    if (en) begin
      s5_ok        <= up.ok;
      s5_wd        <= up.wd;
      s5_wk        <= prod[DIV7_SHIFT +: 6];
      s5_long_cur  <= long_cur;
      s5_long_prev <= long_prev;
      s5_doy       <= up.doy;
      s5_mlen      <= up.mlen;
      s5_leap      <= up.leap;
    end
  end

  always_comb begin
    weeks_cur = s5_long_cur ? ISO_WEEKS_LONG : ISO_WEEKS_SHORT;
    if (s5_wk == 6'd0) begin
      wk_fix = s5_long_prev ? ISO_WEEKS_LONG : ISO_WEEKS_SHORT;
    end else if (s5_wk > weeks_cur) begin
      wk_fix = ISO_WEEK_FIRST;
    end else begin
      wk_fix = s5_wk;
    end
    if (s5_ok) begin
      dn_next.valid_res    = 1'b1;
      dn_next.weekday      = s5_wd;
      dn_next.ordinal_day  = s5_doy;
      dn_next.iso_week     = wk_fix;
      dn_next.leap_year    = s5_leap;
      dn_next.month_length = s5_mlen;
    end else begin
      dn_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= s5_valid;
    end
    if (en) begin
      dn <= dn_next;
    end
  end

endmodule

@@ hw/rtl/gregorian_date_attributes.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_attributes
// Weekday, day of year, ISO week, leap flag and month length of a date.
// ----------------------------------------------------------------------------
// Usage:
//   date channel: date_valid / date_stall / date (year, month, day).
//   attr channel: attr_valid / attr_stall / attr, one result per date.
//   A date moves on the edge where valid is high and stall is low.
//   Six register stages: year split by 100, leap and Zeller terms, date
//   check and Zeller sum, mod 7 and weekday, raw ISO week and 1 January,
//   boundary fixup into the output register. Throughput is one date per
//   cycle while attr is not stalled; the /100 and /7 reciprocal multipliers
//   each sit in their own stage.
//   When attr is stalled with a result waiting, the whole pipeline holds and
//   a one-entry skid register takes the date in flight; date_stall is driven
//   from that register only.
//   Reset (rst, synchronous) empties the pipeline and skid register.
//   Invalid dates give a result with every field zero.
// ----------------------------------------------------------------------------
module gregorian_date_attributes (
  input  logic           clk,
  input  logic           rst,
  input  logic           date_valid,
  output logic           date_stall,
  input  gda_pkg::date_t date,
  output logic           attr_valid,
  input  logic           attr_stall,
  output gda_pkg::attr_t attr
);
  import gda_pkg::*;

  logic  en;
  logic  skid_valid;
  date_t skid_data;
  logic  feed_valid;
  date_t feed_data;

  logic yr_valid;
  yr_t  yr;
  logic cal_valid;
  cal_t cal;

  assign en         = !attr_valid || !attr_stall;
  assign date_stall = skid_valid;
  assign feed_valid = skid_valid || date_valid;
  assign feed_data  = skid_valid ? skid_data : date;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (date_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
    if (!en && !skid_valid) begin
      skid_data <= date;
    end
  end

  gda_year u_year (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (feed_valid),
    .up       (feed_data),
    .dn_valid (yr_valid),
    .dn       (yr)
  );

  gda_cal u_cal (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (yr_valid),
    .up       (yr),
    .dn_valid (cal_valid),
    .dn       (cal)
  );

  gda_week u_week (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (cal_valid),
    .up       (cal),
    .dn_valid (attr_valid),
    .dn       (attr)
  );

endmodule

@@ hw/rtl/gda_check.sv @@
// ----------------------------------------------------------------------------
// gda_check
// Port-level checks on the date attribute block, bound to the top level.
// ----------------------------------------------------------------------------
module gda_check (
  input logic           clk,
  input logic           rst,
  input logic           date_valid,
  input logic           date_stall,
  input gda_pkg::date_t date,
  input logic           attr_valid,
  input logic           attr_stall,
  input gda_pkg::attr_t attr
);
  import gda_pkg::*;

  // reset leaves nothing in flight
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !attr_valid && !date_stall)
    else $error("result or stall present after reset");

  a_attr_hold: assert property (@(posedge clk) disable iff (rst)
    attr_valid && attr_stall |=> attr_valid && $stable(attr))
    else $error("stalled result changed");

  // the input side only stalls after the output was stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(date_stall) |-> $past(attr_valid && attr_stall))
    else $error("input stall without output backpressure");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    attr_valid && !attr.valid_res |-> attr == '0)
    else $error("invalid date with nonzero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    attr_valid && attr.valid_res |->
      attr.ordinal_day != 9'd0 && attr.iso_week != 6'd0 &&
      attr.iso_week <= ISO_WEEKS_LONG && attr.weekday <= WD_SAT &&
      attr.month_length >= 5'd28)
    else $error("valid result out of range");

endmodule

bind gregorian_date_attributes gda_check u_check (.*);
